// ===== hw/rtl/cft_pkg.sv =====
// ----------------------------------------------------------------------------
// cft_pkg
// Shared types, codes and byte classes of the cell formula tokenizer.
// ----------------------------------------------------------------------------
package cft_pkg;

  localparam longint unsigned MAX_TEXT = 64'd1048576;
  localparam int FIFO_DEPTH = 4;

  localparam int KIND_W   = 3;
  localparam int TYPE_W   = 5;
  localparam int OFFSET_W = 20;
  localparam int LENGTH_W = 21;

  // event kinds
  localparam logic [KIND_W-1:0] EV_TOKEN = 3'd0;
  localparam logic [KIND_W-1:0] EV_CELL  = 3'd1;
  localparam logic [KIND_W-1:0] EV_ROW   = 3'd2;
  localparam logic [KIND_W-1:0] EV_RUN   = 3'd3;
  localparam logic [KIND_W-1:0] EV_END   = 3'd4;
  localparam logic [KIND_W-1:0] EV_OPEN  = 3'd5;

  // token types
  localparam logic [TYPE_W-1:0] TT_STRING = 5'd0;
  localparam logic [TYPE_W-1:0] TT_REF    = 5'd1;
  localparam logic [TYPE_W-1:0] TT_NUMBER = 5'd2;
  localparam logic [TYPE_W-1:0] TT_DOLLAR = 5'd3;
  localparam logic [TYPE_W-1:0] TT_QUERY  = 5'd4;
  localparam logic [TYPE_W-1:0] TT_PLUS   = 5'd5;
  localparam logic [TYPE_W-1:0] TT_MINUS  = 5'd6;
  localparam logic [TYPE_W-1:0] TT_STAR   = 5'd7;
  localparam logic [TYPE_W-1:0] TT_SLASH  = 5'd8;
  localparam logic [TYPE_W-1:0] TT_PCT    = 5'd9;
  localparam logic [TYPE_W-1:0] TT_CARET  = 5'd10;
  localparam logic [TYPE_W-1:0] TT_LPAREN = 5'd11;
  localparam logic [TYPE_W-1:0] TT_RPAREN = 5'd12;
  localparam logic [TYPE_W-1:0] TT_LBRACE = 5'd13;
  localparam logic [TYPE_W-1:0] TT_RBRACE = 5'd14;
  localparam logic [TYPE_W-1:0] TT_GT     = 5'd15;
  localparam logic [TYPE_W-1:0] TT_GE     = 5'd16;
  localparam logic [TYPE_W-1:0] TT_LT     = 5'd17;
  localparam logic [TYPE_W-1:0] TT_LE     = 5'd18;
  localparam logic [TYPE_W-1:0] TT_EQ     = 5'd19;
  localparam logic [TYPE_W-1:0] TT_NE     = 5'd20;

  // bytes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QUERY  = 8'h3F;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_TICK   = 8'h60;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [TYPE_W-1:0]   ttype;
    logic [OFFSET_W-1:0] start;
    logic [LENGTH_W-1:0] length;
    logic                last;
  } res_t;

  typedef struct packed {
    logic              hit;
    logic [TYPE_W-1:0] code;
  } sym_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

  function automatic logic is_alnum(logic [7:0] b);
    return is_digit(b) || ((b >= CH_LA) && (b <= CH_LZ)) || ((b >= CH_UA) && (b <= CH_UZ));
  endfunction

  function automatic logic is_blank(logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
  endfunction

  function automatic sym_t single_code(logic [7:0] b);
    sym_t s;
    s.hit = 1'b1;
    unique case (b)
      CH_DOLLAR: s.code = TT_DOLLAR;
      CH_QUERY:  s.code = TT_QUERY;
      CH_PLUS:   s.code = TT_PLUS;
      CH_STAR:   s.code = TT_STAR;
      CH_SLASH:  s.code = TT_SLASH;
      CH_PCT:    s.code = TT_PCT;
      CH_CARET:  s.code = TT_CARET;
      CH_LPAREN: s.code = TT_LPAREN;
      CH_RPAREN: s.code = TT_RPAREN;
      CH_LBRACE: s.code = TT_LBRACE;
      CH_RBRACE: s.code = TT_RBRACE;
      default: begin
        s.hit  = 1'b0;
        s.code = TT_STRING;
      end
    endcase
    return s;
  endfunction

  function automatic logic starts_token(logic [7:0] b);
    sym_t s;
    s = single_code(b);
    return s.hit || is_digit(b) || (b == CH_MINUS) || (b == CH_TICK) ||
           (b == CH_AMP) || (b == CH_GT) || (b == CH_LT);
  endfunction

  function automatic logic run_absorbs(logic [7:0] b);
    return (b >= CH_SPACE) && (b <= CH_DEL) && !starts_token(b);
  endfunction

  function automatic logic [TYPE_W-1:0] held_alone_code(logic [7:0] h);
    if (h == CH_MINUS) return TT_MINUS;
    if (h == CH_GT) return TT_GT;
    return TT_LT;
  endfunction

  function automatic logic [TYPE_W-1:0] pair_code(logic [7:0] h);
    if (h == CH_GT) return TT_GE;
    if (h == CH_LT) return TT_LE;
    if (h == CH_EQ) return TT_EQ;
    return TT_NE;
  endfunction

endpackage

// ===== hw/rtl/cell_formula_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// cell_formula_tokenizer_top
// Streaming tokenizer for spreadsheet cell formulas, one text byte per word.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle while in_stall is low. A byte is
// registered on entry, classified against the scan state once the queue has
// room, and its zero, one or two results are written into a four-entry output
// queue. Input stalls only while the queue holds more than two results; a byte
// that causes two results adds an extra entry to the queue, so the rate of one
// byte per cycle holds only while the output drains one result per cycle and
// each byte causes at most one result. Offsets and lengths saturate at
// MAX_TEXT-1 and MAX_TEXT and are reported in 20 and 21 bits.
module cell_formula_tokenizer_top #(
  parameter longint unsigned MAX_TEXT = cft_pkg::MAX_TEXT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     text_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cft_pkg::KIND_W-1:0]     event_kind,
  output logic [cft_pkg::TYPE_W-1:0]     token_class,
  output logic [cft_pkg::OFFSET_W-1:0]   start_offset,
  output logic [cft_pkg::LENGTH_W-1:0]   token_length,
  output logic                           last_of_burst
);

  localparam int PosW = $clog2(MAX_TEXT);
  localparam int LenW = $clog2(MAX_TEXT + 64'd1);
  localparam logic [PosW-1:0] POS_MAX = PosW'(MAX_TEXT - 64'd1);
  localparam logic [LenW-1:0] LEN_MAX = LenW'(MAX_TEXT);
  localparam int PtrW = $clog2(cft_pkg::FIFO_DEPTH);
  localparam int CntW = PtrW + 1;

  typedef enum logic [5:0] {
    M_IDLE = 6'b000001,
    M_HOLD = 6'b000010,
    M_STR  = 6'b000100,
    M_NUM  = 6'b001000,
    M_REF  = 6'b010000,
    M_RUN  = 6'b100000
  } mode_t;

  function automatic cft_pkg::res_t mk(logic [cft_pkg::KIND_W-1:0] k,
                                       logic [cft_pkg::TYPE_W-1:0] t,
                                       logic [PosW-1:0] s, logic [LenW-1:0] n);
    cft_pkg::res_t r;
    r.kind   = k;
    r.ttype  = t;
    r.start  = cft_pkg::OFFSET_W'(s);
    r.length = cft_pkg::LENGTH_W'(n);
    r.last   = 1'b0;
    return r;
  endfunction

  // input register
  logic       in_full;
  logic [7:0] in_byte;
  logic       go;

  // scan state
  mode_t           mode, mode_next;
  logic [7:0]      held, held_next;
  logic [PosW-1:0] pos, pos_next;
  logic [PosW-1:0] pstart, pstart_next;
  logic [LenW-1:0] plen, plen_next, plen_grow;

  // output queue
  cft_pkg::res_t fifo [cft_pkg::FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            pop;

  // fresh-start outcome for the current byte
  mode_t         fi_mode;
  logic          fi_hold, fi_set, fi_put;
  cft_pkg::res_t fi_res;

  // results of the current byte
  cft_pkg::res_t res_a, res_b, push0, push1;
  logic          a_v, b_v;
  logic [1:0]    push_cnt;

  assign go       = in_full && (count <= CntW'(cft_pkg::FIFO_DEPTH - 2));
  assign in_stall = in_full && !go;
  assign pop      = out_valid && !out_stall;

  assign plen_grow = (plen < LEN_MAX) ? plen + LenW'(1) : LEN_MAX;

  always_comb begin
    cft_pkg::sym_t sc;
    sc      = cft_pkg::single_code(in_byte);
    fi_mode = M_IDLE;
    fi_hold = 1'b0;
    fi_set  = 1'b1;
    fi_put  = 1'b0;
    fi_res  = mk(cft_pkg::EV_RUN, cft_pkg::TT_STRING, pos, LenW'(1));
    priority if (in_byte == cft_pkg::CH_BAR) begin
      fi_set = 1'b0;
      fi_put = 1'b1;
      fi_res = mk(cft_pkg::EV_CELL, cft_pkg::TT_STRING, '0, '0);
    end else if (in_byte == cft_pkg::CH_LF) begin
      fi_set = 1'b0;
      fi_put = 1'b1;
      fi_res = mk(cft_pkg::EV_ROW, cft_pkg::TT_STRING, '0, '0);
    end else if (cft_pkg::is_blank(in_byte)) begin
      fi_set = 1'b0;
    end else if (in_byte == cft_pkg::CH_TICK) begin
      fi_mode = M_STR;
    end else if (in_byte == cft_pkg::CH_AMP) begin
      fi_mode = M_REF;
    end else if (cft_pkg::is_digit(in_byte)) begin
      fi_mode = M_NUM;
    end else if ((in_byte == cft_pkg::CH_MINUS) || (in_byte == cft_pkg::CH_GT) ||
                 (in_byte == cft_pkg::CH_LT) || (in_byte == cft_pkg::CH_EQ) ||
                 (in_byte == cft_pkg::CH_BANG)) begin
      fi_mode = M_HOLD;
      fi_hold = 1'b1;
    end else if (sc.hit) begin
      fi_put = 1'b1;
      fi_res = mk(cft_pkg::EV_TOKEN, sc.code, pos, LenW'(1));
    end else if (cft_pkg::run_absorbs(in_byte)) begin
      fi_mode = M_RUN;
    end else begin
      fi_put = 1'b1;
    end
  end

  always_comb begin
    logic fresh;
    fresh       = 1'b0;
    mode_next   = mode;
    held_next   = held;
    pstart_next = pstart;
    plen_next   = plen;
    pos_next    = (pos < POS_MAX) ? pos + PosW'(1) : pos;
    a_v         = 1'b0;
    b_v         = 1'b0;
    res_a       = mk(cft_pkg::EV_RUN, cft_pkg::TT_STRING, pstart, plen);
    res_b       = fi_res;
    if (in_byte == cft_pkg::CH_NUL) begin
      a_v = 1'b1;
      unique case (mode)
        M_STR: res_a = mk(cft_pkg::EV_OPEN, cft_pkg::TT_STRING, pstart, plen);
        M_NUM: res_a = mk(cft_pkg::EV_TOKEN, cft_pkg::TT_NUMBER, pstart, plen);
        M_REF: res_a = mk(cft_pkg::EV_TOKEN, cft_pkg::TT_REF, pstart, plen);
        M_RUN: res_a = mk(cft_pkg::EV_RUN, cft_pkg::TT_STRING, pstart, plen);
        M_HOLD: begin
          if ((held == cft_pkg::CH_EQ) || (held == cft_pkg::CH_BANG)) begin
            res_a = mk(cft_pkg::EV_RUN, cft_pkg::TT_STRING, pstart, LenW'(1));
          end else begin
            res_a = mk(cft_pkg::EV_TOKEN, cft_pkg::held_alone_code(held), pstart, LenW'(1));
          end
        end
        default: a_v = 1'b0;
      endcase
      b_v         = 1'b1;
      res_b       = mk(cft_pkg::EV_END, cft_pkg::TT_STRING, '0, '0);
      mode_next   = M_IDLE;
      held_next   = '0;
      pos_next    = '0;
      pstart_next = '0;
      plen_next   = '0;
    end else begin
      unique case (mode)
        M_STR: begin
          plen_next = plen_grow;
          if (in_byte == cft_pkg::CH_TICK) begin
            a_v       = 1'b1;
            res_a     = mk(cft_pkg::EV_TOKEN, cft_pkg::TT_STRING, pstart, plen_grow);
            mode_next = M_IDLE;
          end
        end
        M_NUM: begin
          if (cft_pkg::is_digit(in_byte)) begin
            plen_next = plen_grow;
          end else begin
            a_v   = 1'b1;
            res_a = mk(cft_pkg::EV_TOKEN, cft_pkg::TT_NUMBER, pstart, plen);
            fresh = 1'b1;
          end
        end
        M_REF: begin
          if (cft_pkg::is_alnum(in_byte)) begin
            plen_next = plen_grow;
          end else begin
            a_v   = 1'b1;
            res_a = mk(cft_pkg::EV_TOKEN, cft_pkg::TT_REF, pstart, plen);
            fresh = 1'b1;
          end
        end
        M_RUN: begin
          if (cft_pkg::run_absorbs(in_byte)) begin
            plen_next = plen_grow;
          end else begin
            a_v   = 1'b1;
            fresh = 1'b1;
          end
        end
        M_HOLD: begin
          priority if ((held == cft_pkg::CH_MINUS) && cft_pkg::is_digit(in_byte)) begin
            mode_next = M_NUM;
            plen_next = LenW'(2);
          end else if (held == cft_pkg::CH_MINUS) begin
            a_v   = 1'b1;
            res_a = mk(cft_pkg::EV_TOKEN, cft_pkg::TT_MINUS, pstart, LenW'(1));
            fresh = 1'b1;
          end else if (in_byte == cft_pkg::CH_EQ) begin
            a_v       = 1'b1;
            res_a     = mk(cft_pkg::EV_TOKEN, cft_pkg::pair_code(held), pstart, LenW'(2));
            mode_next = M_IDLE;
          end else if ((held == cft_pkg::CH_GT) || (held == cft_pkg::CH_LT)) begin
            a_v   = 1'b1;
            res_a = mk(cft_pkg::EV_TOKEN, cft_pkg::held_alone_code(held), pstart, LenW'(1));
            fresh = 1'b1;
          end else if (cft_pkg::run_absorbs(in_byte)) begin
            mode_next = M_RUN;
            plen_next = LenW'(2);
          end else begin
            a_v   = 1'b1;
            res_a = mk(cft_pkg::EV_RUN, cft_pkg::TT_STRING, pstart, LenW'(1));
            fresh = 1'b1;
          end
        end
        default: fresh = 1'b1;
      endcase
      if (fresh) begin
        mode_next = fi_mode;
        b_v       = fi_put;
        if (fi_hold) begin
          held_next = in_byte;
        end
        if (fi_set) begin
          pstart_next = pos;
          plen_next   = LenW'(1);
        end
      end
    end
    if (b_v) begin
      res_b.last = 1'b1;
    end else begin
      res_a.last = 1'b1;
    end
  end

  always_comb begin
    push0    = a_v ? res_a : res_b;
    push1    = res_b;
    push_cnt = go ? (2'(a_v) + 2'(b_v)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      mode    <= M_IDLE;
      held    <= '0;
      pos     <= '0;
      pstart  <= '0;
      plen    <= '0;
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        in_full <= 1'b1;
      end else if (go) begin
        in_full <= 1'b0;
      end
      if (go) begin
        mode   <= mode_next;
        held   <= held_next;
        pos    <= pos_next;
        pstart <= pstart_next;
        plen   <= plen_next;
      end
      wr_ptr <= wr_ptr + PtrW'(push_cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count + CntW'(push_cnt) - CntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= text_byte;
    end
    if (push_cnt != 2'd0) begin
      fifo[wr_ptr] <= push0;
    end
    if (push_cnt == 2'd2) begin
      fifo[wr_ptr + PtrW'(1)] <= push1;
    end
  end

  assign out_valid     = (count != '0);
  assign event_kind    = fifo[rd_ptr].kind;
  assign token_class   = fifo[rd_ptr].ttype;
  assign start_offset  = fifo[rd_ptr].start;
  assign token_length  = fifo[rd_ptr].length;
  assign last_of_burst = fifo[rd_ptr].last;

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(cft_pkg::FIFO_DEPTH))
    else $error("output queue overfilled");

  a_end_resets : assert property (@(posedge clk) disable iff (rst)
    go && (in_byte == cft_pkg::CH_NUL) |=> (pos == '0) && (mode == M_IDLE))
    else $error("scan state not cleared after end of text");

  a_pos_monotonic : assert property (@(posedge clk) disable iff (rst)
    go && (in_byte != cft_pkg::CH_NUL) |=> pos >= $past(pos))
    else $error("byte position went backward");

  a_end_last : assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == cft_pkg::EV_END) |-> last_of_burst)
    else $error("end of text not marked last of burst");

endmodule

// ===== tb/sv/tb_cell_formula_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// tb_cell_formula_tokenizer_top
// Self-checking bench for the streaming cell formula tokenizer.
// ----------------------------------------------------------------------------
// Directed texts cover the special cases first: strings, unterminated
// strings, signed numbers, references, held symbols, unknown runs and lone
// control bytes. Random formula-like texts follow, mixed with noise bytes.
// Each accepted text byte runs through a local scanner that queues the
// expected events, and each accepted result is compared field by field
// against the oldest queued event. Both sides idle at random in phases one
// and two; in phase three one long output hold stalls the block's input.
module tb_cell_formula_tokenizer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cft_pkg::*;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_HOLD, SCAN_STR, SCAN_NUM, SCAN_REF, SCAN_RUN
  } scan_t;

  localparam int TARGET_BYTES    = 950;
  localparam int STUCK_LIMIT     = 1000;
  localparam int PRESSURE_CYCLES = 48;
  localparam int TAIL_CYCLES     = 12;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          text_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [KIND_W-1:0]   event_kind;
  logic [TYPE_W-1:0]   token_class;
  logic [OFFSET_W-1:0] start_offset;
  logic [LENGTH_W-1:0] token_length;
  logic                last_of_burst;

  cell_formula_tokenizer_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .text_byte     (text_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_kind    (event_kind),
    .token_class   (token_class),
    .start_offset  (start_offset),
    .token_length  (token_length),
    .last_of_burst (last_of_burst)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0] text_q[$];
  res_t       event_burst[$];
  res_t       expected_events[$];

  int total_bytes = 0;
  int bytes_done = 0;
  int events_done = 0;
  int texts_done = 0;
  int mismatches = 0;
  int stuck_cycles = 0;
  int hold_left = 0;
  bit pressure_done = 1'b0;
  int kind_seen[6] = '{default: 0};

  scan_t                scan = SCAN_IDLE;
  logic [7:0]           held = '0;
  logic [OFFSET_W-1:0]  pos = '0;
  logic [OFFSET_W-1:0]  tok_start = '0;
  logic [LENGTH_W-1:0]  tok_len = '0;

  // ---------------------------------------------------------------- scanner

  function automatic bit is_dec(logic [7:0] b);
    return b >= CH_0 && b <= CH_9;
  endfunction

  function automatic bit is_word(logic [7:0] b);
    return is_dec(b) || (b >= CH_LA && b <= CH_LZ) || (b >= CH_UA && b <= CH_UZ);
  endfunction

  function automatic int sym_type(logic [7:0] b);
    case (b)
      CH_DOLLAR: return TT_DOLLAR;
      CH_QUERY:  return TT_QUERY;
      CH_PLUS:   return TT_PLUS;
      CH_STAR:   return TT_STAR;
      CH_SLASH:  return TT_SLASH;
      CH_PCT:    return TT_PCT;
      CH_CARET:  return TT_CARET;
      CH_LPAREN: return TT_LPAREN;
      CH_RPAREN: return TT_RPAREN;
      CH_LBRACE: return TT_LBRACE;
      CH_RBRACE: return TT_RBRACE;
      default:   return -1;
    endcase
  endfunction

  function automatic bit opens_token(logic [7:0] b);
    return sym_type(b) >= 0 || is_dec(b) || b == CH_MINUS || b == CH_TICK ||
           b == CH_AMP || b == CH_GT || b == CH_LT;
  endfunction

  function automatic bit joins_run(logic [7:0] b);
    return b >= CH_SPACE && b <= CH_DEL && !opens_token(b);
  endfunction

  function automatic logic [TYPE_W-1:0] lone_type(logic [7:0] h);
    if (h == CH_MINUS) return TT_MINUS;
    if (h == CH_GT) return TT_GT;
    return TT_LT;
  endfunction

  function automatic logic [LENGTH_W-1:0] grown(logic [LENGTH_W-1:0] n);
    return (n < MAX_TEXT) ? n + 1'b1 : LENGTH_W'(MAX_TEXT);
  endfunction

  function automatic void emit(logic [KIND_W-1:0] k, logic [TYPE_W-1:0] t,
                               logic [OFFSET_W-1:0] s, logic [LENGTH_W-1:0] n);
    res_t r;
    r.kind   = k;
    r.ttype  = t;
    r.start  = s;
    r.length = n;
    r.last   = 1'b0;
    event_burst.push_back(r);
  endfunction

  function automatic void open_token(logic [7:0] b, logic [OFFSET_W-1:0] at);
    int sc;
    sc = sym_type(b);
    scan = SCAN_IDLE;
    if (b == CH_BAR) begin
      emit(EV_CELL, '0, '0, '0);
      return;
    end
    if (b == CH_LF) begin
      emit(EV_ROW, '0, '0, '0);
      return;
    end
    if (b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF || b == CH_CR) return;
    tok_start = at;
    tok_len = LENGTH_W'(1);
    if (b == CH_TICK) scan = SCAN_STR;
    else if (b == CH_AMP) scan = SCAN_REF;
    else if (is_dec(b)) scan = SCAN_NUM;
    else if (b == CH_MINUS || b == CH_GT || b == CH_LT || b == CH_EQ || b == CH_BANG) begin
      scan = SCAN_HOLD;
      held = b;
    end else if (sc >= 0) emit(EV_TOKEN, TYPE_W'(sc), at, LENGTH_W'(1));
    else if (joins_run(b)) scan = SCAN_RUN;
    else emit(EV_RUN, '0, at, LENGTH_W'(1));
  endfunction

  function automatic void flush_pending();
    case (scan)
      SCAN_STR: emit(EV_OPEN, '0, tok_start, tok_len);
      SCAN_NUM: emit(EV_TOKEN, TT_NUMBER, tok_start, tok_len);
      SCAN_REF: emit(EV_TOKEN, TT_REF, tok_start, tok_len);
      SCAN_RUN: emit(EV_RUN, '0, tok_start, tok_len);
      SCAN_HOLD: begin
        if (held == CH_EQ || held == CH_BANG) emit(EV_RUN, '0, tok_start, LENGTH_W'(1));
        else emit(EV_TOKEN, lone_type(held), tok_start, LENGTH_W'(1));
      end
      default: ;
    endcase
  endfunction

  function automatic void tokenize_byte(logic [7:0] b);
    logic [OFFSET_W-1:0] at;
    logic [TYPE_W-1:0]   pair;
    res_t                r;
    at = pos;
    event_burst.delete();
    if (b == CH_NUL) begin
      flush_pending();
      emit(EV_END, '0, '0, '0);
      scan = SCAN_IDLE;
      held = '0;
      pos = '0;
      tok_start = '0;
      tok_len = '0;
    end else begin
      case (scan)
        SCAN_STR: begin
          tok_len = grown(tok_len);
          if (b == CH_TICK) begin
            emit(EV_TOKEN, TT_STRING, tok_start, tok_len);
            scan = SCAN_IDLE;
          end
        end
        SCAN_NUM, SCAN_REF: begin
          if (scan == SCAN_NUM ? is_dec(b) : is_word(b)) tok_len = grown(tok_len);
          else begin
            emit(EV_TOKEN, scan == SCAN_NUM ? TT_NUMBER : TT_REF, tok_start, tok_len);
            open_token(b, at);
          end
        end
        SCAN_RUN: begin
          if (joins_run(b)) tok_len = grown(tok_len);
          else begin
            emit(EV_RUN, '0, tok_start, tok_len);
            open_token(b, at);
          end
        end
        SCAN_HOLD: begin
          if (held == CH_MINUS && is_dec(b)) begin
            scan = SCAN_NUM;
            tok_len = LENGTH_W'(2);
          end else if (held == CH_MINUS) begin
            emit(EV_TOKEN, TT_MINUS, tok_start, LENGTH_W'(1));
            open_token(b, at);
          end else if (b == CH_EQ) begin
            case (held)
              CH_GT:   pair = TT_GE;
              CH_LT:   pair = TT_LE;
              CH_EQ:   pair = TT_EQ;
              default: pair = TT_NE;
            endcase
            emit(EV_TOKEN, pair, tok_start, LENGTH_W'(2));
            scan = SCAN_IDLE;
          end else if (held == CH_GT || held == CH_LT) begin
            emit(EV_TOKEN, lone_type(held), tok_start, LENGTH_W'(1));
            open_token(b, at);
          end else if (joins_run(b)) begin
            scan = SCAN_RUN;
            tok_len = LENGTH_W'(2);
          end else begin
            emit(EV_RUN, '0, tok_start, LENGTH_W'(1));
            open_token(b, at);
          end
        end
        default: open_token(b, at);
      endcase
      if (pos < MAX_TEXT - 1) pos = pos + 1'b1;
    end
    foreach (event_burst[i]) begin
      r = event_burst[i];
      r.last = (i == event_burst.size() - 1);
      expected_events.push_back(r);
    end
  endfunction

  // -------------------------------------------------------------- stimulus

  function automatic logic [7:0] word_char(int i);
    if (i < 10) return CH_0 + 8'(i);
    if (i < 36) return CH_LA + 8'(i - 10);
    return CH_UA + 8'(i - 36);
  endfunction

  task automatic add_piece();
    logic [7:0] syms[12] = '{CH_DOLLAR, CH_QUERY, CH_PLUS, CH_STAR, CH_SLASH, CH_PCT,
                             CH_CARET, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
                             CH_MINUS};
    logic [7:0] rels[4] = '{CH_GT, CH_LT, CH_EQ, CH_BANG};
    logic [7:0] blanks[5] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
    logic [7:0] c;
    int n;
    case ($urandom_range(15))
      0: begin
        text_q.push_back(CH_TICK);
        n = $urandom_range(5);
        repeat (n) begin
          c = 8'($urandom_range(32, 126));
          text_q.push_back(c == CH_TICK ? CH_SPACE : c);
        end
        text_q.push_back(CH_TICK);
      end
      1, 2: begin
        if ($urandom_range(1)) text_q.push_back(CH_MINUS);
        n = $urandom_range(1, 4);
        repeat (n) text_q.push_back(word_char($urandom_range(9)));
      end
      3: begin
        text_q.push_back(CH_AMP);
        n = $urandom_range(4);
        repeat (n) text_q.push_back(word_char($urandom_range(61)));
      end
      4, 5: text_q.push_back(syms[$urandom_range(11)]);
      6: begin
        text_q.push_back(rels[$urandom_range(3)]);
        if ($urandom_range(3) != 0) text_q.push_back(CH_EQ);
      end
      7: text_q.push_back(blanks[$urandom_range(4)]);
      8: text_q.push_back(CH_BAR);
      9: text_q.push_back(CH_LF);
      10: begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          do c = 8'($urandom_range(32, 127)); while (!joins_run(c));
          text_q.push_back(c);
        end
      end
      11: text_q.push_back($urandom_range(1) ? CH_EQ : CH_BANG);
      12: text_q.push_back($urandom_range(1) ? 8'($urandom_range(1, 31))
                                             : 8'($urandom_range(128, 255)));
      default: text_q.push_back(8'($urandom_range(1, 255)));
    endcase
  endtask

  task automatic build_texts();
    logic [7:0] directed[] = '{
      CH_TICK, CH_LZ, CH_TICK,
      CH_MINUS, CH_9,
      CH_AMP, CH_UA, CH_0, CH_BAR,
      8'h01, 8'hFF,
      CH_BANG, CH_EQ,
      CH_GT, CH_GT, CH_LT, CH_EQ,
      CH_EQ, CH_DEL, CH_LF,
      8'h80, CH_MINUS, CH_DOLLAR,
      CH_TICK, CH_LA, CH_NUL,
      CH_BANG, CH_NUL,
      CH_NUL
    };
    int pieces;
    foreach (directed[i]) text_q.push_back(directed[i]);
    while (text_q.size() < TARGET_BYTES) begin
      pieces = $urandom_range(1, 12);
      repeat (pieces) add_piece();
      if ($urandom_range(9) == 0) begin
        text_q.push_back(CH_TICK);
        text_q.push_back(word_char($urandom_range(61)));
      end
      text_q.push_back(CH_NUL);
    end
    total_bytes = text_q.size();
  endtask

  // ------------------------------------------------------ driver and monitor

  function automatic int idle_phase();
    if (bytes_done * 3 < total_bytes) return 0;
    if (bytes_done * 3 < total_bytes * 2) return 1;
    return 2;
  endfunction

  function automatic int send_idle_pct();
    case (idle_phase())
      0:       return 25;
      1:       return 62;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct();
    case (idle_phase())
      0:       return 62;
      1:       return 25;
      default: return 0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      text_byte <= '0;
    end else if (!in_valid || !in_stall) begin
      if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
        in_valid <= 1'b1;
        text_byte <= text_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // hold the output for a long stretch once, early in the back-to-back phase
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!pressure_done && idle_phase() == 2 &&
                 bytes_done * 4 >= total_bytes * 3) begin
      out_stall <= 1'b1;
      hold_left <= PRESSURE_CYCLES - 1;
      pressure_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct());
    end
  end

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        tokenize_byte(text_byte);
        bytes_done <= bytes_done + 1;
        if (text_byte == CH_NUL) texts_done <= texts_done + 1;
      end
      if (out_valid && !out_stall) begin
        events_done <= events_done + 1;
        if (event_kind <= EV_OPEN) kind_seen[event_kind]++;
        if (expected_events.size() == 0) begin
          $error("result with no expectation: event_kind %0d, start_offset %0d",
                 event_kind, start_offset);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", 64'(want.kind), 64'(event_kind));
          check_field("token_class", 64'(want.ttype), 64'(token_class));
          check_field("start_offset", 64'(want.start), 64'(start_offset));
          check_field("token_length", 64'(want.length), 64'(token_length));
          check_field("last_of_burst", 64'(want.last), 64'(last_of_burst));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STUCK_LIMIT);
      $display("** cell_formula_tokenizer_top: FAILED **");
      $finish;
    end
  end

  initial begin
    build_texts();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk); while (text_q.size() != 0 || in_valid || expected_events.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_events.size() != 0) begin
      $error("%0d expected results never arrived", expected_events.size());
      mismatches++;
    end
    $display("Streamed %0d bytes in %0d texts and checked %0d results: %0d tokens,",
             bytes_done, texts_done, events_done, kind_seen[EV_TOKEN]);
    $display("%0d cell/row breaks, %0d unknown runs, %0d unterminated strings, %0d mismatches.",
             kind_seen[EV_CELL] + kind_seen[EV_ROW], kind_seen[EV_RUN],
             kind_seen[EV_OPEN], mismatches);
    if (mismatches == 0) begin
      $display("** cell_formula_tokenizer_top: PASSED **");
    end else begin
      $display("** cell_formula_tokenizer_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/cft_pkg.sv
hw/rtl/cell_formula_tokenizer_top.sv
tb/sv/tb_cell_formula_tokenizer_top.sv
